@@ sv/dehb_pkg.sv @@
// shared types and constants of the two-exposure hdr pixel blend
package dehb_pkg;

  // one input item: long and short exposure pixel plus frame marker
  typedef struct packed {
    logic [15:0] long_red;
    logic [15:0] long_green;
    logic [15:0] long_blue;
    logic [15:0] short_red;
    logic [15:0] short_green;
    logic [15:0] short_blue;
    logic        frame_end;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [23:0] merged_red;
    logic [23:0] merged_green;
    logic [23:0] merged_blue;
    logic [7:0]  recovered_ev;
    logic        frame_end_out;
  } out_item_t;

  // register map, by word index
  typedef enum logic [2:0] {
    REG_BLEND_ENABLE  = 3'd0,
    REG_EXPOSURE_RATIO = 3'd1,
    REG_BLEND_START   = 3'd2,
    REG_BLEND_END     = 3'd3,
    REG_GAIN_RED      = 3'd4,
    REG_GAIN_GREEN    = 3'd5,
    REG_GAIN_BLUE     = 3'd6,
    REG_MAX_STOPS     = 3'd7
  } reg_idx_e;

  // weight class from the luminance compare
  typedef enum logic [1:0] {
    WCLS_ONE  = 2'd0,
    WCLS_ZERO = 2'd1,
    WCLS_RAMP = 2'd2
  } wcls_e;

  localparam logic [16:0] W_ONE   = 17'd65536;
  localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

  // luminance weights, Q0.16
  localparam logic [15:0] LUMA_R = 16'd13933;
  localparam logic [15:0] LUMA_G = 16'd46871;
  localparam logic [15:0] LUMA_B = 16'd4732;

endpackage

@@ sv/dehb_scale_lane.sv @@
// one colour lane of short exposure scaling: ratio then flicker gain
module dehb_scale_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] short_i,
  input  logic [15:0] ratio_i,
  input  logic [14:0] gain_i,
  output logic [23:0] scaled_o
);

  logic [24:0] a_q;
  logic [39:0] b_full;
  logic [25:0] b_shift;
  logic [23:0] b_q;

  // exposure ratio, rounded Q8.8
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= 25'((33'(short_i) * 33'(ratio_i) + 33'd128) >> 8);
    end
  end

  // flicker gain, rounded Q1.14, saturated
  always_comb begin
    b_full  = 40'(a_q) * 40'(gain_i) + 40'd8192;
    b_shift = 26'(b_full >> 14);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q <= (b_shift > 26'(dehb_pkg::OUT_MAX)) ? dehb_pkg::OUT_MAX : b_shift[23:0];
    end
  end

  assign scaled_o = b_q;

endmodule

@@ sv/dehb_weight.sv @@
// luminance to long exposure weight: compare, pipelined divider, cosine table
module dehb_weight #(
  parameter int WEIGHT_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] y_i,
  input  logic [15:0] lvl_start_i,
  input  logic [15:0] lvl_end_i,
  output logic [16:0] w_o
);

  localparam int QB = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int NW = 16 + QB;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // raised cosine entry, cos^2 via horner series in Q30
  function automatic logic [16:0] weight_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] c2;
    logic [63:0] w;
    x  = (64'd1686629713 * 64'(idx)) / 64'(WEIGHT_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    q  = ((x2 * t) >> 30) / 64'd90;
    t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    q  = ((x2 * t) >> 30) / 64'd56;
    t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    q  = ((x2 * t) >> 30) / 64'd30;
    t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    q  = ((x2 * t) >> 30) / 64'd12;
    t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    q  = ((x2 * t) >> 30) / 64'd2;
    t  = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    c2 = (t * t) >> 30;
    w  = (c2 + 64'd8192) >> 14;
    return (w > 64'(dehb_pkg::W_ONE)) ? dehb_pkg::W_ONE : 17'(w);
  endfunction

  logic [16:0]     rom [WEIGHT_TABLE_DEPTH];
  logic [NW-1:0]   rem_q [QB+1];
  logic [15:0]     den_q [QB+1];
  logic [QB-1:0]   quo_q [QB+1];
  dehb_pkg::wcls_e cls_q [QB+1];
  dehb_pkg::wcls_e cls_d;
  logic [15:0]     diff;
  logic [16:0]     w_q;

  // constant cosine table
  for (genvar i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [16:0] Entry = weight_entry(i);
    assign rom[i] = Entry;
  end

  // classify luminance against the blend window
  always_comb begin
    diff = y_i - lvl_start_i;
    if (y_i <= lvl_start_i) begin
      cls_d = dehb_pkg::WCLS_ONE;
    end else if (y_i >= lvl_end_i) begin
      cls_d = dehb_pkg::WCLS_ZERO;
    end else begin
      cls_d = dehb_pkg::WCLS_RAMP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q[0] <= cls_d;
      rem_q[0] <= NW'({{QB{1'b0}}, diff} * NW'(WEIGHT_TABLE_DEPTH));
      den_q[0] <= lvl_end_i - lvl_start_i;
      quo_q[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [NW-1:0] dsh;
    logic          take;
    assign dsh  = {{QB{1'b0}}, den_q[k]} << B;
    assign take = rem_q[k] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cls_q[k+1] <= cls_q[k];
        den_q[k+1] <= den_q[k];
        rem_q[k+1] <= take ? rem_q[k] - dsh : rem_q[k];
        quo_q[k+1] <= quo_q[k] | (QB'(take) << B);
      end
    end
  end

  // table read and class select
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (cls_q[QB])
        dehb_pkg::WCLS_ONE:  w_q <= dehb_pkg::W_ONE;
        dehb_pkg::WCLS_RAMP: w_q <= rom[quo_q[QB]];
        default:             w_q <= '0;
      endcase
    end
  end

  assign w_o = w_q;

endmodule

@@ sv/dehb_log2.sv @@
// recovered ev: msb search then four squaring stages for the fraction
module dehb_log2 #(
  parameter int PIXEL_FRACTION_BITS = 12
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] peak_i,
  input  logic        act_i,
  input  logic [7:0]  max_ev_i,
  output logic [7:0]  ev_o
);

  logic [4:0]  n;
  logic        ge_one;
  logic [31:0] m_q [5];
  logic [3:0]  f_q [5];
  logic [3:0]  int_q [5];
  logic        ok_q [5];
  logic [7:0]  ev_raw;

  // leading one and normalised mantissa
  always_comb begin
    n = '0;
    for (int i = 0; i < 24; i++) begin
      if (peak_i[i]) begin
        n = 5'(i);
      end
    end
    ge_one = peak_i[23:PIXEL_FRACTION_BITS] != '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= 32'(peak_i) << (5'd31 - n);
      int_q[0] <= 4'(n - 5'(PIXEL_FRACTION_BITS));
      f_q[0]   <= '0;
      ok_q[0]  <= act_i && ge_one;
    end
  end

  // each squaring yields one fraction bit
  for (genvar k = 0; k < 4; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(m_q[k]) * 64'(m_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k+1]   <= sq[63] ? sq[63:32] : sq[62:31];
        f_q[k+1]   <= f_q[k] | (sq[63] ? (4'd8 >> k) : 4'd0);
        int_q[k+1] <= int_q[k];
        ok_q[k+1]  <= ok_q[k];
      end
    end
  end

  // clamp to the configured limit, zero unless reported
  always_comb begin
    ev_raw = {int_q[4], f_q[4]};
    if (!ok_q[4]) begin
      ev_o = '0;
    end else begin
      ev_o = (ev_raw > max_ev_i) ? max_ev_i : ev_raw;
    end
  end

endmodule

@@ sv/dehb_blend_lane.sv @@
// one colour lane of the weighted long/short blend
module dehb_blend_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] w_i,
  input  logic [15:0] long_i,
  input  logic [23:0] short_i,
  input  logic        pass_i,
  output logic [23:0] merged_o
);

  logic [32:0] pl_q;
  logic [40:0] ps_q;
  logic [15:0] long_q;
  logic        pass_q;
  logic [41:0] sum;
  logic [25:0] sum_sh;
  logic [23:0] out_q;

  // weighted products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= 33'(w_i) * 33'(long_i);
      ps_q   <= 41'(dehb_pkg::W_ONE - w_i) * 41'(short_i);
      long_q <= long_i;
      pass_q <= pass_i;
    end
  end

  // rounded sum, saturated
  always_comb begin
    sum    = 42'(pl_q) + 42'(ps_q) + 42'd32768;
    sum_sh = 26'(sum >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (pass_q) begin
        out_q <= 24'(long_q);
      end else begin
        out_q <= (sum_sh > 26'(dehb_pkg::OUT_MAX)) ? dehb_pkg::OUT_MAX : sum_sh[23:0];
      end
    end
  end

  assign merged_o = out_q;

endmodule

@@ sv/dual_exposure_hdr_pixel_blend.sv @@
// top level of the two-exposure hdr pixel blend
//
// Input channel in_valid_i/in_ready_o carries one long and one short
// exposure pixel per item; output channel out_valid_o/out_ready_i returns
// one merged pixel per item, in order. Registers sit on an APB-style port,
// written by the user only while the block is idle; not enforced here.
// Throughput: one item per clock. The pipeline is one stall domain whose
// enable is the free state of the output skid stage.
// The pipeline runs from acceptance through the one-bit-per-stage
// divider of the weight ramp index, the cosine table and the blend
// multipliers to the output register.
// The frame peak is taken between items in order, so recovered_ev on the
// frame's last item covers the whole frame.
// Reset clears all valid flags, the peak and the registers to their
// defaults; no item is in flight afterwards.
// When the receiver stalls, the output register holds its item and a skid
// stage takes one more, then in_ready_o drops until the skid drains.
module dual_exposure_hdr_pixel_blend #(
  parameter int WEIGHT_TABLE_DEPTH  = 256,
  parameter int PIXEL_FRACTION_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dehb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dehb_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int QB  = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int WL  = QB + 2;
  localparam int TL  = WL + 2;
  localparam int EVD = TL - 5;

  // configuration registers
  logic        enable_q;
  logic [15:0] ratio_q;
  logic [15:0] start_q;
  logic [15:0] end_q;
  logic [14:0] gain_r_q;
  logic [14:0] gain_g_q;
  logic [14:0] gain_b_q;
  logic [7:0]  max_stops_q;
  dehb_pkg::reg_idx_e widx;

  assign widx   = dehb_pkg::reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      ratio_q     <= 16'd4096;
      start_q     <= 16'd3277;
      end_q       <= 16'd3891;
      gain_r_q    <= 15'd16384;
      gain_g_q    <= 15'd16384;
      gain_b_q    <= 15'd16384;
      max_stops_q <= 8'd48;
    end else if (psel && penable && pwrite) begin
      case (widx)
        dehb_pkg::REG_BLEND_ENABLE:   enable_q    <= pwdata[0];
        dehb_pkg::REG_EXPOSURE_RATIO: ratio_q     <= pwdata[15:0];
        dehb_pkg::REG_BLEND_START:    start_q     <= pwdata[15:0];
        dehb_pkg::REG_BLEND_END:      end_q       <= pwdata[15:0];
        dehb_pkg::REG_GAIN_RED:       gain_r_q    <= pwdata[14:0];
        dehb_pkg::REG_GAIN_GREEN:     gain_g_q    <= pwdata[14:0];
        dehb_pkg::REG_GAIN_BLUE:      gain_b_q    <= pwdata[14:0];
        default:                      max_stops_q <= pwdata[7:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    case (widx)
      dehb_pkg::REG_BLEND_ENABLE:   prdata = 32'(enable_q);
      dehb_pkg::REG_EXPOSURE_RATIO: prdata = 32'(ratio_q);
      dehb_pkg::REG_BLEND_START:    prdata = 32'(start_q);
      dehb_pkg::REG_BLEND_END:      prdata = 32'(end_q);
      dehb_pkg::REG_GAIN_RED:       prdata = 32'(gain_r_q);
      dehb_pkg::REG_GAIN_GREEN:     prdata = 32'(gain_g_q);
      dehb_pkg::REG_GAIN_BLUE:      prdata = 32'(gain_b_q);
      default:                      prdata = 32'(max_stops_q);
    endcase
  end

  // pipeline enable and valid line
  logic               adv;
  logic               skid_v_q;
  logic               out_v_q;
  logic [2:0]         v_q;
  logic [TL-1:0]      vt_q;
  logic               push;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;
  assign push       = vt_q[TL-1] && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vt_q <= '0;
    end else if (adv) begin
      v_q  <= {v_q[1:0], in_valid_i};
      vt_q <= {vt_q[TL-2:0], v_q[2]};
    end
  end

  // input register
  dehb_pkg::in_item_t p0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= in_data_i;
    end
  end

  // luminance products and long pixel carry
  logic [31:0] yr_q, yg_q, yb_q;
  logic [15:0] l1_q [3];
  logic [15:0] l2_q [3];
  logic        fe1_q, fe2_q, en1_q, en2_q;
  logic [15:0] y2_q;
  logic [33:0] ysum;

  assign ysum = 34'(yr_q) + 34'(yg_q) + 34'(yb_q) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yr_q    <= 32'(p0_q.long_red)   * 32'(dehb_pkg::LUMA_R);
      yg_q    <= 32'(p0_q.long_green) * 32'(dehb_pkg::LUMA_G);
      yb_q    <= 32'(p0_q.long_blue)  * 32'(dehb_pkg::LUMA_B);
      l1_q[0] <= p0_q.long_red;
      l1_q[1] <= p0_q.long_green;
      l1_q[2] <= p0_q.long_blue;
      fe1_q   <= p0_q.frame_end;
      en1_q   <= enable_q;
      y2_q    <= 16'(ysum >> 16);
      l2_q    <= l1_q;
      fe2_q   <= fe1_q;
      en2_q   <= en1_q;
    end
  end

  // scaling lanes
  logic [23:0] sc [3];
  dehb_scale_lane u_scale_r (
    .clk_i, .en_i(adv), .short_i(p0_q.short_red), .ratio_i(ratio_q),
    .gain_i(gain_r_q), .scaled_o(sc[0])
  );
  dehb_scale_lane u_scale_g (
    .clk_i, .en_i(adv), .short_i(p0_q.short_green), .ratio_i(ratio_q),
    .gain_i(gain_g_q), .scaled_o(sc[1])
  );
  dehb_scale_lane u_scale_b (
    .clk_i, .en_i(adv), .short_i(p0_q.short_blue), .ratio_i(ratio_q),
    .gain_i(gain_b_q), .scaled_o(sc[2])
  );

  // merge of the lanes: channel maximum and frame peak
  logic [23:0] peak_q;
  logic [23:0] mx;
  logic [23:0] peak_incl;

  always_comb begin
    mx = sc[0];
    if (sc[1] > mx) mx = sc[1];
    if (sc[2] > mx) mx = sc[2];
    peak_incl = (en2_q && (mx > peak_q)) ? mx : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (adv && v_q[2]) begin
      peak_q <= fe2_q ? 24'd0 : peak_incl;
    end
  end

  // long exposure weight
  logic [16:0] w;
  dehb_weight #(.WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)) u_weight (
    .clk_i, .en_i(adv), .y_i(y2_q), .lvl_start_i(start_q), .lvl_end_i(end_q),
    .w_o(w)
  );

  // recovered ev
  logic [7:0] ev_l;
  dehb_log2 #(.PIXEL_FRACTION_BITS(PIXEL_FRACTION_BITS)) u_log2 (
    .clk_i, .en_i(adv), .peak_i(peak_incl), .act_i(en2_q && fe2_q),
    .max_ev_i(max_stops_q), .ev_o(ev_l)
  );

  // side band delay lines up to the blend lanes and the output
  logic [15:0] ld_q  [WL][3];
  logic [23:0] sd_q  [WL][3];
  logic        end_d_q [WL];
  logic        fed_q [TL];
  logic [7:0]  evd_q [EVD];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld_q[0]    <= l2_q;
      sd_q[0]    <= sc;
      end_d_q[0] <= en2_q;
      fed_q[0]   <= fe2_q;
      evd_q[0]   <= ev_l;
      for (int i = 1; i < WL; i++) begin
        ld_q[i]    <= ld_q[i-1];
        sd_q[i]    <= sd_q[i-1];
        end_d_q[i] <= end_d_q[i-1];
      end
      for (int i = 1; i < TL; i++) begin
        fed_q[i] <= fed_q[i-1];
      end
      for (int i = 1; i < EVD; i++) begin
        evd_q[i] <= evd_q[i-1];
      end
    end
  end

  // blend lanes
  logic [23:0] mg [3];
  for (genvar c = 0; c < 3; c++) begin : g_blend
    dehb_blend_lane u_blend (
      .clk_i, .en_i(adv), .w_i(w), .long_i(ld_q[WL-1][c]),
      .short_i(sd_q[WL-1][c]), .pass_i(!end_d_q[WL-1]), .merged_o(mg[c])
    );
  end

  dehb_pkg::out_item_t res;
  always_comb begin
    res.merged_red    = mg[0];
    res.merged_green  = mg[1];
    res.merged_blue   = mg[2];
    res.recovered_ev  = evd_q[EVD-1];
    res.frame_end_out = fed_q[TL-1];
  end

  // output register and skid stage
  dehb_pkg::out_item_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= push;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/dehb_checker.sv @@
// port checker of the hdr pixel blend and its bind
module dehb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dehb_pkg::out_item_t out_data_o
);

  // nothing leaves the block and in_ready_o is high once reset has been applied
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("item or stall during reset");

  // ev is reported only on the frame's last item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_end_out |-> out_data_o.recovered_ev == 8'd0)
    else $error("recovered ev outside frame end");

  // a stalled item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // a stalled item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output item changed while stalled");

endmodule

bind dual_exposure_hdr_pixel_blend dehb_checker u_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o(out_data_o)
);
